// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of the clock, reset or not.
`define MSP_ASSERT_CLK(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("msp_checker: property failed");

// Property checked at every rising edge of the clock outside of reset.
`define MSP_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("msp_checker: property failed");

`endif

// ----- src/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg
// Shared constants, codes, types and helpers of the servo pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  // Table size and output pin count.
  localparam int MAX_CHANNELS = 16;
  localparam int PIN_COUNT    = 32;
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

  // Field widths.
  localparam int CMD_W       = 3;
  localparam int PIN_W       = 5;
  localparam int VAL_W       = 16;
  localparam int LEVEL_W     = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int TPU_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int CMP_W       = VAL_W + TPU_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ATTACH      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DETACH      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_US    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE_ANGLE = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TICKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 2'd3;

  // Configuration reset values.
  localparam logic [VAL_W-1:0] RST_MIN_PULSE    = 16'd1000;
  localparam logic [VAL_W-1:0] RST_MAX_PULSE    = 16'd2000;
  localparam logic [VAL_W-1:0] RST_FRAME_TICKS  = 16'd40000;
  localparam logic [TPU_W-1:0] RST_TICKS_PER_US = 4'd2;

  // Angle scaling: width = min + angle * (max - min) / 180. The division by
  // 180 is a shift by two and a reciprocal multiply by 1/45 with correction.
  localparam int ANGLE_FULL    = 180;
  localparam int ANGLE_QUARTER = ANGLE_FULL / 4;
  localparam int ANG_W         = 8;
  localparam int PROD_W        = ANG_W + VAL_W;
  localparam int Y_W           = PROD_W - 2;
  localparam int DIV_SHIFT     = Y_W;
  localparam int RECIP         = (1 << DIV_SHIFT) / ANGLE_QUARTER;
  localparam int RECIP_W       = $clog2(RECIP + 1);
  localparam int MUL_W         = Y_W + RECIP_W;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PIN_W-1:0] pin;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] min_us;
    logic [VAL_W-1:0] max_us;
    logic [VAL_W-1:0] frame_ticks;
    logic [TPU_W-1:0] ticks_per_us;
  } cfg_t;

  typedef struct packed {
    logic               ok;
    logic [LEVEL_W-1:0] levels;
    logic [CNT_W-1:0]   count;
  } result_t;

  // One-hot level bit of a pin; pins without an output give an empty mask.
  function automatic logic [LEVEL_W-1:0] pin_mask(input logic [PIN_W-1:0] p);
    logic [LEVEL_W-1:0] m;
    m = '0;
    if (int'(p) < PIN_COUNT) begin
      m[p] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- src/msp_angle.sv -----
// ----------------------------------------------------------------------------
// msp_angle
// Two-stage pipeline that turns an angle in degrees into a pulse width.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_angle (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [msp_pkg::VAL_W-1:0] value_in,
  input  wire msp_pkg::cfg_t             cfg,
  output logic      [msp_pkg::VAL_W-1:0] width,
  output logic                           angle_ok
);

  logic [msp_pkg::VAL_W-1:0]  diff;
  logic [msp_pkg::PROD_W-1:0] prod;
  logic                       ok_b;
  logic [msp_pkg::Y_W-1:0]    y;
  logic [msp_pkg::MUL_W-1:0]  recip_prod;
  logic [msp_pkg::Y_W-1:0]    y_c;
  logic [msp_pkg::VAL_W-1:0]  q0_c;
  logic                       ok_c;
  logic [msp_pkg::Y_W-1:0]    q0_times;
  logic [msp_pkg::Y_W-1:0]    rem;
  logic [msp_pkg::VAL_W-1:0]  quot;

  assign diff = cfg.max_us - cfg.min_us;
  assign y    = prod[msp_pkg::PROD_W-1:2];
  assign recip_prod = msp_pkg::MUL_W'(y) * msp_pkg::MUL_W'(msp_pkg::RECIP);

  // Stage B forms the product, stage C the quotient estimate, which is at
  // most one below the true quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= msp_pkg::PROD_W'(value_in[msp_pkg::ANG_W-1:0])
              * msp_pkg::PROD_W'(diff);
      ok_b <= (value_in <= msp_pkg::VAL_W'(msp_pkg::ANGLE_FULL))
              && (cfg.min_us <= cfg.max_us);
      y_c  <= y;
      q0_c <= msp_pkg::VAL_W'(recip_prod >> msp_pkg::DIV_SHIFT);
      ok_c <= ok_b;
    end
  end

  assign q0_times = msp_pkg::Y_W'(q0_c) * msp_pkg::Y_W'(msp_pkg::ANGLE_QUARTER);
  assign rem      = y_c - q0_times;
  assign quot     = q0_c
                    + msp_pkg::VAL_W'(rem >= msp_pkg::Y_W'(msp_pkg::ANGLE_QUARTER));
  assign width    = cfg.min_us + quot;
  assign angle_ok = ok_c;

endmodule

`default_nettype wire

// ----- src/msp_table.sv -----
// ----------------------------------------------------------------------------
// msp_table
// Channel table, frame counter and pin levels, updated once per item.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire msp_pkg::item_t            item,
  input  wire logic [msp_pkg::VAL_W-1:0] angle_width,
  input  wire logic                      angle_ok,
  input  wire msp_pkg::cfg_t             cfg,
  output msp_pkg::result_t               result
);

  logic [msp_pkg::PIN_W-1:0]   chan_pin   [msp_pkg::MAX_CHANNELS];
  logic [msp_pkg::VAL_W-1:0]   chan_width [msp_pkg::MAX_CHANNELS];
  logic [msp_pkg::PIN_W-1:0]   shift_pin  [msp_pkg::MAX_CHANNELS];
  logic [msp_pkg::VAL_W-1:0]   shift_width[msp_pkg::MAX_CHANNELS];
  logic [msp_pkg::CNT_W-1:0]   count;
  logic [msp_pkg::VAL_W-1:0]   frame_counter;
  logic [msp_pkg::LEVEL_W-1:0] levels;

  logic [msp_pkg::MAX_CHANNELS-1:0] lane_valid;
  logic [msp_pkg::MAX_CHANNELS-1:0] match;
  logic [msp_pkg::MAX_CHANNELS-1:0] first;
  logic [msp_pkg::MAX_CHANNELS-1:0] after;
  logic                             any_match;
  logic                             has_room;
  logic                             frame_start;
  logic [msp_pkg::VAL_W-1:0]        fc_tick;
  logic [msp_pkg::LEVEL_W-1:0]      set_mask;
  logic [msp_pkg::LEVEL_W-1:0]      clr_mask;
  logic [msp_pkg::VAL_W-1:0]        wr_us;
  logic                             set_ok;

  logic                        ok_next;
  logic [msp_pkg::CNT_W-1:0]   count_next;
  logic [msp_pkg::LEVEL_W-1:0] levels_next;
  logic [msp_pkg::VAL_W-1:0]   fc_next;
  logic                        do_attach;
  logic                        do_detach;
  logic                        do_write;

  // Lane matching: the first attached lane with the pin, and every lane from
  // there on, which moves down by one on a detach.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < msp_pkg::MAX_CHANNELS; i++) begin
      lane_valid[i] = msp_pkg::CNT_W'(i) < count;
      match[i]      = lane_valid[i] && (chan_pin[i] == item.pin);
      first[i]      = match[i] && !seen;
      seen          = seen | match[i];
      after[i]      = seen;
    end
  end

  assign any_match   = |match;
  assign has_room    = count < msp_pkg::CNT_W'(msp_pkg::MAX_CHANNELS);
  assign frame_start = frame_counter >= cfg.frame_ticks;
  assign fc_tick     = frame_start ? '0 : frame_counter + 1'b1;

  // Each lane compares its own width, scaled to ticks, against the counter.
  always_comb begin
    logic [msp_pkg::CMP_W-1:0] cmp;
    set_mask = '0;
    clr_mask = '0;
    for (int i = 0; i < msp_pkg::MAX_CHANNELS; i++) begin
      cmp = msp_pkg::CMP_W'(cfg.ticks_per_us) * msp_pkg::CMP_W'(chan_width[i]);
      if (lane_valid[i]) begin
        set_mask = set_mask | msp_pkg::pin_mask(chan_pin[i]);
        if (cmp <= msp_pkg::CMP_W'(fc_tick)) begin
          clr_mask = clr_mask | msp_pkg::pin_mask(chan_pin[i]);
        end
      end
    end
  end

  assign wr_us  = (item.cmd == msp_pkg::CMD_WRITE_US) ? item.value : angle_width;
  assign set_ok = (wr_us >= cfg.min_us) && (wr_us <= cfg.max_us) && any_match
                  && ((item.cmd == msp_pkg::CMD_WRITE_US) || angle_ok);

  always_comb begin
    ok_next     = 1'b0;
    count_next  = count;
    levels_next = levels;
    fc_next     = frame_counter;
    do_attach   = 1'b0;
    do_detach   = 1'b0;
    do_write    = 1'b0;
    case (item.cmd)
      msp_pkg::CMD_TICK: begin
        fc_next     = fc_tick;
        levels_next = (levels | (frame_start ? set_mask : '0)) & ~clr_mask;
        ok_next     = 1'b1;
      end
      msp_pkg::CMD_ATTACH: begin
        if (has_room) begin
          do_attach   = 1'b1;
          count_next  = count + 1'b1;
          levels_next = levels & ~msp_pkg::pin_mask(item.pin);
          ok_next     = 1'b1;
        end
      end
      msp_pkg::CMD_DETACH: begin
        if (any_match) begin
          do_detach   = 1'b1;
          count_next  = count - 1'b1;
          levels_next = levels & ~msp_pkg::pin_mask(item.pin);
          ok_next     = 1'b1;
        end
      end
      msp_pkg::CMD_WRITE_US, msp_pkg::CMD_WRITE_ANGLE: begin
        if (set_ok) begin
          do_write = 1'b1;
          ok_next  = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      frame_counter <= '0;
      levels        <= '0;
    end else if (fire) begin
      count         <= count_next;
      frame_counter <= fc_next;
      levels        <= levels_next;
    end
  end

  for (genvar g = 0; g < msp_pkg::MAX_CHANNELS; g++) begin : g_lane
    if (g + 1 < msp_pkg::MAX_CHANNELS) begin : g_src
      assign shift_pin[g]   = chan_pin[g + 1];
      assign shift_width[g] = chan_width[g + 1];
    end else begin : g_last
      assign shift_pin[g]   = chan_pin[g];
      assign shift_width[g] = chan_width[g];
    end

    always_ff @(posedge clk) begin
      if (fire) begin
        if (do_attach && (msp_pkg::CNT_W'(g) == count)) begin
          chan_pin[g]   <= item.pin;
          chan_width[g] <= item.value;
        end else if (do_detach && after[g]) begin
          chan_pin[g]   <= shift_pin[g];
          chan_width[g] <= shift_width[g];
        end else if (do_write && first[g]) begin
          chan_width[g] <= wr_us;
        end
      end
    end
  end

  assign result.ok     = ok_next;
  assign result.levels = levels_next;
  assign result.count  = count_next;

endmodule

`default_nettype wire

// ----- src/multi_servo_pulse_generator.sv -----
// ----------------------------------------------------------------------------
// multi_servo_pulse_generator
// Servo pulse generator for up to sixteen channels on thirty-two pins.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless stalled, tick or command,
// and returns one result per item with the ok flag, the level of every pin
// after the item and the number of attached channels. An item passes stage A
// and the angle conversion, with the angle times range product in stage B and
// the reciprocal multiply dividing by 180 in stage C; the table applies it as
// it moves into the result register. All sixteen channels are compared
// against the frame counter in parallel on each tick, so ticks and commands
// alike sustain one item per cycle unless stalled. A one-entry skid buffer
// at the input and the result register at the output keep the stall
// signals of the two sides apart, so in_stall is a plain register.
// There is no clearing pass after reset: the block takes items at once. The
// configuration port is always ready; registers must only be written while no
// item is in flight, since the pipeline reads them on its way through.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_servo_pulse_generator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input items.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [msp_pkg::CMD_W-1:0]       command,
  input  wire logic [msp_pkg::PIN_W-1:0]       pin,
  input  wire logic [msp_pkg::VAL_W-1:0]       value,
  // Result items.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 ok,
  output logic      [msp_pkg::LEVEL_W-1:0]     pin_levels,
  output logic      [msp_pkg::COUNT_OUT_W-1:0] channel_count,
  // Configuration writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  msp_pkg::cfg_t    cfg;
  msp_pkg::item_t   port_item;
  msp_pkg::item_t   skid_item;
  msp_pkg::item_t   a_item;
  msp_pkg::item_t   b_item;
  msp_pkg::item_t   c_item;
  msp_pkg::result_t result;

  logic                      skid_full;
  logic                      a_valid;
  logic                      b_valid;
  logic                      c_valid;
  logic                      adv;
  logic                      in_accept;
  logic [msp_pkg::VAL_W-1:0] angle_width;
  logic                      angle_ok;

  assign port_item.cmd   = command;
  assign port_item.pin   = pin;
  assign port_item.value = value;

  // The whole pipeline moves together whenever the result register is free
  // or being emptied this cycle.
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = skid_full;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Control state: configuration registers, skid flag and stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_us       <= msp_pkg::RST_MIN_PULSE;
      cfg.max_us       <= msp_pkg::RST_MAX_PULSE;
      cfg.frame_ticks  <= msp_pkg::RST_FRAME_TICKS;
      cfg.ticks_per_us <= msp_pkg::RST_TICKS_PER_US;
      skid_full        <= 1'b0;
      a_valid          <= 1'b0;
      b_valid          <= 1'b0;
      c_valid          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          msp_pkg::REG_MIN_PULSE:    cfg.min_us       <= cfg_data;
          msp_pkg::REG_MAX_PULSE:    cfg.max_us       <= cfg_data;
          msp_pkg::REG_FRAME_TICKS:  cfg.frame_ticks  <= cfg_data;
          msp_pkg::REG_TICKS_PER_US: cfg.ticks_per_us <= cfg_data[msp_pkg::TPU_W-1:0];
          default: begin
            cfg.min_us <= cfg.min_us;
          end
        endcase
      end
      if (adv) begin
        // A parked item has priority; the port is stalled while it waits.
        a_valid   <= skid_full || in_accept;
        b_valid   <= a_valid;
        c_valid   <= b_valid;
        out_valid <= c_valid;
        skid_full <= 1'b0;
      end else if (in_accept) begin
        skid_full <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= skid_full ? skid_item : port_item;
      b_item <= a_item;
      c_item <= b_item;
      if (c_valid) begin
        ok            <= result.ok;
        pin_levels    <= result.levels;
        channel_count <= msp_pkg::COUNT_OUT_W'(result.count);
      end
    end else if (in_accept) begin
      skid_item <= port_item;
    end
  end

  // Angle to width conversion runs alongside stages B and C for every item;
  // only angle commands use its answer.
  msp_angle u_angle (
    .clk      (clk),
    .en       (adv),
    .value_in (a_item.value),
    .cfg      (cfg),
    .width    (angle_width),
    .angle_ok (angle_ok)
  );

  // The item in stage C updates the table as it moves into the result
  // register, so the result shows the state just after that item.
  msp_table u_table (
    .clk         (clk),
    .rst         (rst),
    .fire        (adv && c_valid),
    .item        (c_item),
    .angle_width (angle_width),
    .angle_ok    (angle_ok),
    .cfg         (cfg),
    .result      (result)
  );

  // b_item is carried only to keep stage C aligned with the angle unit.

endmodule

`default_nettype wire

// ----- src/msp_checker.sv -----
// ----------------------------------------------------------------------------
// msp_checker
// Port-level assertions for the servo pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module msp_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            ok,
  input wire logic [msp_pkg::LEVEL_W-1:0]     pin_levels,
  input wire logic [msp_pkg::COUNT_OUT_W-1:0] channel_count
);

  // Reset empties the pipeline and releases the input.
  `MSP_ASSERT_CLK(a_reset_idle, clk, rst |=> (!out_valid && !in_stall))

  // A stalled result stays put.
  `MSP_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(ok) && $stable(pin_levels) && $stable(channel_count)))

  // The table never holds more channels than it has lanes.
  `MSP_ASSERT(a_count_bound, clk, rst, out_valid |-> (int'(channel_count) <= msp_pkg::MAX_CHANNELS))

  // A pin can only be high while some channel drives it.
  `MSP_ASSERT(a_empty_low, clk, rst, (out_valid && (channel_count == '0)) |-> (pin_levels == '0))

endmodule

bind multi_servo_pulse_generator msp_checker u_msp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .ok            (ok),
  .pin_levels    (pin_levels),
  .channel_count (channel_count)
);

`default_nettype wire

// ----- bench/multi_servo_pulse_generator_tb.sv -----
// ----------------------------------------------------------------------------
// multi_servo_pulse_generator_tb
// Self-checking bench for the multi-channel servo pulse generator. A short
// table of directed items is followed by random items under several register
// settings. Every result item is checked against a hand-written result or an
// in-bench model of the channel table, the frame counter and the pin levels,
// with random idling on the input and the result side.
// ----------------------------------------------------------------------------
module multi_servo_pulse_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  // Command codes the block does not define; it must refuse them.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES    = 8;
  // The settle time before a register write and at the end is a margin on
  // top of waiting for every result to come back.
  localparam int PIPE_SETTLE     = 6;
  // Longest correct stretch without any handshake is one pause on one side
  // plus the settle time, so this limit is far beyond any good run.
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int PHASES          = 7;
  localparam int DIRECTED_ROWS   = 23;

  typedef struct packed {
    logic                   ok;
    logic [LEVEL_W-1:0]     levels;
    logic [COUNT_OUT_W-1:0] count;
  } servo_result_t;

  // One row of the directed table. When retime is set, the bench drains the
  // block and loads the short-frame setting before sending the row's item.
  // When typed is set, want holds the result written out by hand.
  typedef struct packed {
    logic             retime;
    logic [CMD_W-1:0] cmd;
    logic [PIN_W-1:0] pin;
    logic [VAL_W-1:0] value;
    logic             typed;
    servo_result_t    want;
  } directed_row_t;

  // A register setting, plus the width range and attach share that make the
  // random items interesting under it.
  typedef struct packed {
    logic [15:0] min_us, max_us, frame, tpu_data, wlo, whi;
    logic [7:0]  attach_pct;
  } phase_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [CMD_W-1:0]       command   = '0;
  logic [PIN_W-1:0]       pin       = '0;
  logic [VAL_W-1:0]       value     = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   ok;
  logic [LEVEL_W-1:0]     pin_levels;
  logic [COUNT_OUT_W-1:0] channel_count;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // When steady is high neither side idles.
  logic                   steady    = 1'b0;
  int                     out_hold  = 0;
  int                     quiet_cycles = 0;
  int                     mismatches   = 0;

  multi_servo_pulse_generator u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .pin           (pin),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ok            (ok),
    .pin_levels    (pin_levels),
    .channel_count (channel_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Channel table model. It mirrors the block after reset and is advanced
  // once per accepted item, in acceptance order.
  // --------------------------------------------------------------------------
  logic [PIN_W-1:0]   chan_pin   [MAX_CHANNELS];
  logic [VAL_W-1:0]   chan_width [MAX_CHANNELS];
  int                 chan_count = 0;
  logic [VAL_W-1:0]   frame_pos  = '0;
  logic [LEVEL_W-1:0] level_img  = '0;
  logic [VAL_W-1:0]   cfg_min    = RST_MIN_PULSE;
  logic [VAL_W-1:0]   cfg_max    = RST_MAX_PULSE;
  logic [VAL_W-1:0]   cfg_frame  = RST_FRAME_TICKS;
  logic [TPU_W-1:0]   cfg_tpu    = RST_TICKS_PER_US;

  function automatic int first_channel(input logic [PIN_W-1:0] p);
    for (int i = 0; i < chan_count; i++) begin
      if (chan_pin[i] == p) begin
        return i;
      end
    end
    return -1;
  endfunction

  // A width is taken only inside [min, max] and only for a pin in the table.
  function automatic logic store_width(input logic [PIN_W-1:0] p, input int unsigned us);
    int k;
    if (us < 32'(cfg_min) || us > 32'(cfg_max)) begin
      return 1'b0;
    end
    k = first_channel(p);
    if (k < 0) begin
      return 1'b0;
    end
    chan_width[k] = 16'(us);
    return 1'b1;
  endfunction

  function automatic servo_result_t next_servo_result(input item_t it);
    servo_result_t r;
    int            k;
    int unsigned   span;
    r.ok = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        // The counter clears on the tick after it reaches the frame length;
        // that tick is the frame start and raises every attached pin.
        if (frame_pos >= cfg_frame) begin
          frame_pos = '0;
          for (int i = 0; i < chan_count; i++) begin
            level_img[chan_pin[i]] = 1'b1;
          end
        end else begin
          frame_pos = frame_pos + 1'b1;
        end
        // Any channel of a pin that reached its compare value pulls it low.
        for (int i = 0; i < chan_count; i++) begin
          if (32'(cfg_tpu) * 32'(chan_width[i]) <= 32'(frame_pos)) begin
            level_img[chan_pin[i]] = 1'b0;
          end
        end
        r.ok = 1'b1;
      end
      CMD_ATTACH: begin
        if (chan_count < MAX_CHANNELS) begin
          chan_pin[chan_count]   = it.pin;
          chan_width[chan_count] = it.value;
          chan_count++;
          level_img[it.pin] = 1'b0;
          r.ok = 1'b1;
        end
      end
      CMD_DETACH: begin
        k = first_channel(it.pin);
        if (k >= 0) begin
          for (int i = k; i < chan_count - 1; i++) begin
            chan_pin[i]   = chan_pin[i + 1];
            chan_width[i] = chan_width[i + 1];
          end
          chan_count--;
          level_img[it.pin] = 1'b0;
          r.ok = 1'b1;
        end
      end
      CMD_WRITE_US: begin
        r.ok = store_width(it.pin, 32'(it.value));
      end
      CMD_WRITE_ANGLE: begin
        if (32'(it.value) <= 32'(ANGLE_FULL) && cfg_min <= cfg_max) begin
          span = 32'(cfg_max) - 32'(cfg_min);
          r.ok = store_width(it.pin,
                             32'(cfg_min) + 32'(it.value) * span / 32'(ANGLE_FULL));
        end
      end
      default: begin
      end
    endcase
    r.levels = level_img;
    r.count  = COUNT_OUT_W'(chan_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus tables.
  // --------------------------------------------------------------------------
  // The first rows run under the reset setting, where nothing has ticked far
  // enough to raise a pin, so their results can be written out by hand. From
  // the retime row on, a three-tick frame with one tick per microsecond lets
  // a frame start and the falling edges show up within a few items.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b0, CMD_TICK,        5'd0,  16'h0000, 1'b1, '{1'b1, 32'd0, 5'd0}},
    '{1'b0, CMD_SPARE_LO,    5'd31, 16'hFFFF, 1'b1, '{1'b0, 32'd0, 5'd0}},
    '{1'b0, CMD_DETACH,      5'd4,  16'd0,    1'b1, '{1'b0, 32'd0, 5'd0}},
    '{1'b0, CMD_WRITE_US,    5'd4,  16'd1500, 1'b1, '{1'b0, 32'd0, 5'd0}},
    '{1'b0, CMD_ATTACH,      5'd4,  16'd1500, 1'b1, '{1'b1, 32'd0, 5'd1}},
    '{1'b0, CMD_WRITE_US,    5'd4,  16'd999,  1'b1, '{1'b0, 32'd0, 5'd1}},
    '{1'b0, CMD_WRITE_US,    5'd4,  16'd2001, 1'b1, '{1'b0, 32'd0, 5'd1}},
    '{1'b0, CMD_WRITE_US,    5'd4,  16'd2000, 1'b1, '{1'b1, 32'd0, 5'd1}},
    '{1'b0, CMD_WRITE_ANGLE, 5'd4,  16'd181,  1'b1, '{1'b0, 32'd0, 5'd1}},
    '{1'b0, CMD_WRITE_ANGLE, 5'd4,  16'd180,  1'b1, '{1'b1, 32'd0, 5'd1}},
    '{1'b0, CMD_WRITE_ANGLE, 5'd4,  16'd0,    1'b1, '{1'b1, 32'd0, 5'd1}},
    '{1'b1, CMD_ATTACH,      5'd31, 16'hFFFF, 1'b0, '0},
    '{1'b0, CMD_ATTACH,      5'd0,  16'd0,    1'b0, '0},
    '{1'b0, CMD_ATTACH,      5'd4,  16'd2,    1'b0, '0},
    '{1'b0, CMD_WRITE_ANGLE, 5'd4,  16'd90,   1'b0, '0},
    '{1'b0, CMD_TICK,        5'd0,  16'd0,    1'b0, '0},
    '{1'b0, CMD_TICK,        5'd0,  16'd0,    1'b0, '0},
    '{1'b0, CMD_TICK,        5'd0,  16'd0,    1'b0, '0},
    '{1'b0, CMD_TICK,        5'd0,  16'd0,    1'b0, '0},
    '{1'b0, CMD_TICK,        5'd0,  16'd0,    1'b0, '0},
    '{1'b0, CMD_DETACH,      5'd4,  16'd0,    1'b0, '0},
    '{1'b0, CMD_TICK,        5'd0,  16'd0,    1'b0, '0},
    '{1'b0, CMD_SPARE_HI,    5'd31, 16'h5A5A, 1'b0, '0}
  };

  localparam phase_t SHORT_FRAME = '{16'd0, 16'd40, 16'd3, 16'd1, 16'd0, 16'd0, 8'd0};

  // Settings for the random part: a plain frame, a zero frame where every
  // tick restarts it, min above max so every width write is refused, the
  // largest frame with zero ticks per microsecond written with junk in the
  // upper data bits, a one-tick frame with min equal to max, a table that
  // fills up, and a final setting run without any idling.
  phase_t random_phases [PHASES] = '{
    '{16'd5,     16'd40,    16'd60,    16'd1,     16'd0,  16'd70,    8'd12},
    '{16'd0,     16'd65535, 16'd0,     16'd3,     16'd0,  16'd6,     8'd12},
    '{16'd100,   16'd50,    16'd200,   16'd15,    16'd0,  16'd20,    8'd15},
    '{16'd0,     16'd65535, 16'd65535, 16'hFFF0,  16'd0,  16'd65535, 8'd12},
    '{16'd65535, 16'd65535, 16'd1,     16'd2,     16'd0,  16'd3,     8'd12},
    '{16'd10,    16'd30,    16'd100,   16'd4,     16'd0,  16'd30,    8'd40},
    '{16'd20,    16'd60,    16'd80,    16'd1,     16'd10, 16'd70,    8'd12}
  };

  // Widths mostly fall where they matter against the frame, with the range
  // edges and full 16-bit values mixed in.
  function automatic logic [VAL_W-1:0] width_value(input phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 16'($urandom_range(ph.wlo, ph.whi));
    end else if (roll < 75) begin
      return 16'($urandom_range(ph.min_us, ph.max_us));
    end else if (roll < 80) begin
      return ph.min_us;
    end else if (roll < 85) begin
      return ph.max_us;
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly ticks and well-formed commands on a handful of pins, so that
  // writes and detaches find their channels; the rest hits any pin.
  function automatic item_t random_item(input phase_t ph);
    item_t it;
    int    roll;
    int    base;
    roll = $urandom_range(0, 99);
    base = int'(ph.attach_pct);
    it.pin   = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 5))
                                          : 5'($urandom_range(0, 31));
    it.value = 16'($urandom_range(0, 65535));
    if (roll < base) begin
      it.cmd   = CMD_ATTACH;
      it.value = width_value(ph);
    end else if (roll < base + 10) begin
      it.cmd = CMD_DETACH;
    end else if (roll < base + 20) begin
      it.cmd   = CMD_WRITE_US;
      it.value = width_value(ph);
    end else if (roll < base + 30) begin
      it.cmd = CMD_WRITE_ANGLE;
      if ($urandom_range(0, 4) != 0) begin
        it.value = 16'($urandom_range(0, ANGLE_FULL));
      end
    end else if (roll < base + 33) begin
      it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end else begin
      it.cmd = CMD_TICK;
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. An item is taken at an edge where in_valid is high and
  // in_stall is low; the model is advanced at that edge. The payload is held
  // until then, and valid stays high into the next item unless a gap follows.
  // --------------------------------------------------------------------------
  servo_result_t pending_results [$];

  task automatic send_item(input item_t it, input logic typed, input servo_result_t want);
    servo_result_t predicted;
    in_valid <= 1'b1;
    command  <= it.cmd;
    pin      <= it.pin;
    value    <= it.value;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = next_servo_result(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic pause_input();
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_MIN_PULSE:    cfg_min   = d;
      REG_MAX_PULSE:    cfg_max   = d;
      REG_FRAME_TICKS:  cfg_frame = d;
      REG_TICKS_PER_US: cfg_tpu   = d[TPU_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Registers are only written with nothing in flight: every result has
  // come back, and the pipeline has had time to empty.
  task automatic load_setting(input phase_t s);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_SETTLE) @(posedge clk);
    write_reg(REG_MIN_PULSE, s.min_us);
    write_reg(REG_MAX_PULSE, s.max_us);
    write_reg(REG_FRAME_TICKS, s.frame);
    write_reg(REG_TICKS_PER_US, s.tpu_data);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    item_t it;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].retime) begin
        load_setting(SHORT_FRAME);
      end
      it.cmd   = directed_rows[r].cmd;
      it.pin   = directed_rows[r].pin;
      it.value = directed_rows[r].value;
      send_item(it, directed_rows[r].typed, directed_rows[r].want);
      pause_input();
    end

    for (int p = 0; p < PHASES; p++) begin
      load_setting(random_phases[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Idling is switched off now and then for a stretch, and for good in
        // the last setting.
        if (n % 40 == 0) begin
          steady <= (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
        end
        send_item(random_item(random_phases[p]), 1'b0, '0);
        pause_input();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. The bench stalls in bursts unless steady is set, and checks
  // each accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || steady) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_hold != 0) begin
      out_stall <= 1'b1;
      out_hold  <= out_hold - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      out_hold  <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    servo_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result item", 32'd0, pin_levels);
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok) begin
          report("ok", 32'(want.ok), 32'(ok));
        end
        if (pin_levels !== want.levels) begin
          report("pin_levels", want.levels, pin_levels);
        end
        if (channel_count !== want.count) begin
          report("channel_count", 32'(want.count), 32'(channel_count));
        end
      end
    end
  end

  // Any handshake on any channel counts as progress; a long run of cycles
  // without one means the block has hung or lost results.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/msp_pkg.sv
src/msp_angle.sv
src/msp_table.sv
src/multi_servo_pulse_generator.sv
src/msp_checker.sv
bench/multi_servo_pulse_generator_tb.sv
